### rtl/kps_pkg.sv
// shared types and constants of the matrix keypad scanner
`default_nettype none

package kps_pkg;

    // register indexes of the configuration port
    localparam logic [1:0] CFG_SETTLE_TICKS     = 2'd0;
    localparam logic [1:0] CFG_DEBOUNCE_SAMPLES = 2'd1;
    localparam logic [1:0] CFG_START_KEY_CODE   = 2'd2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // reset values of the registers
    localparam logic [15:0] SETTLE_RESET   = 16'd200;
    localparam logic [3:0]  DEBOUNCE_RESET = 4'd10;
    localparam logic [4:0]  START_RESET    = 5'd25;

    // column drive patterns
    localparam logic [7:0] COL_IDLE  = 8'hFF;
    localparam logic [7:0] COL_FIRST = 8'hFE;

    typedef struct packed {
        logic       begin_scan;
        logic       start_pin;
        logic [2:0] row_pins;
        logic [4:0] override_key;
    } t_kps_in;

    typedef struct packed {
        logic [7:0] column_drive;
        logic       busy_res;
        logic       done_res;
        logic [4:0] key_code;
        logic       beep;
    } t_kps_res;

    typedef struct packed {
        logic [15:0] settle_ticks;
        logic [3:0]  debounce_samples;
        logic [4:0]  start_key_code;
    } t_kps_cfg;

endpackage

`default_nettype wire

### rtl/kps_in_if.sv
// input channel of the keypad scanner: one tick of pin samples per transaction
`default_nettype none

interface kps_in_if;
    logic       valid;
    logic       ready;
    logic       begin_scan;
    logic       start_pin;
    logic [2:0] row_pins;
    logic [4:0] override_key;

    modport source (output valid, begin_scan, start_pin, row_pins, override_key, input ready);
    modport sink   (input valid, begin_scan, start_pin, row_pins, override_key, output ready);
endinterface

`default_nettype wire

### rtl/kps_out_if.sv
// result channel of the keypad scanner
`default_nettype none

interface kps_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] column_drive;
    logic       busy_res;
    logic       done_res;
    logic [4:0] key_code;
    logic       beep;

    modport source (output valid, column_drive, busy_res, done_res, key_code, beep,
                    input ready);
    modport sink   (input valid, column_drive, busy_res, done_res, key_code, beep,
                    output ready);
endinterface

`default_nettype wire

### rtl/kps_in_stage.sv
// input register stage of the keypad scanner
`default_nettype none

module kps_in_stage
    import kps_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_ready,
    input  wire t_kps_in i_item,
    input  wire logic    i_take,
    output logic         o_valid,
    output t_kps_in      o_item
);

    logic    r_valid;
    logic    n_valid;
    t_kps_in r_item;
    logic    w_accept;

    assign o_ready  = !r_valid || i_take;
    assign w_accept = i_valid && o_ready;

    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

### rtl/kps_step.sv
// scan state machine: one step per tick, state registers and next-state logic
`default_nettype none

module kps_step
    import kps_pkg::*;
#(
    parameter int NUM_COLUMNS = 8
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_take,
    input  wire t_kps_in  i_item,
    input  wire t_kps_cfg i_cfg,
    output t_kps_res      o_res
);

    localparam logic [1:0] PH_IDLE     = 2'd0;
    localparam logic [1:0] PH_DEBOUNCE = 2'd1;
    localparam logic [1:0] PH_SCAN     = 2'd2;

    localparam logic [2:0] LAST_COL = 3'(NUM_COLUMNS - 1);

    logic [1:0]  r_phase,   n_phase;
    logic [2:0]  r_col,     n_col;
    logic [7:0]  r_pattern, n_pattern;
    logic [15:0] r_settle,  n_settle;
    logic [3:0]  r_deb,     n_deb;
    logic [4:0]  r_base,    n_base;

    logic        w_do_deb;
    logic [3:0]  w_deb_cnt;
    logic [15:0] w_settle_inc;
    logic [2:0]  w_pressed;
    logic [4:0]  w_row_add;
    logic        w_done;
    logic [4:0]  w_code;
    logic        w_beep;

    always_comb begin
        n_phase   = r_phase;
        n_col     = r_col;
        n_pattern = r_pattern;
        n_settle  = r_settle;
        n_deb     = r_deb;
        n_base    = r_base;
        w_done    = 1'b0;
        w_code    = '0;
        w_beep    = 1'b0;
        w_do_deb  = 1'b0;

        w_settle_inc = r_settle + 16'd1;
        w_pressed    = ~i_item.row_pins;
        // highest pressed row wins
        if (w_pressed[2]) begin
            w_row_add = 5'd3;
        end else if (w_pressed[1]) begin
            w_row_add = 5'd2;
        end else begin
            w_row_add = 5'd1;
        end

        unique case (r_phase)
            PH_DEBOUNCE: begin
                w_do_deb = 1'b1;
            end
            PH_SCAN: begin
                n_settle = w_settle_inc;
                if (w_settle_inc >= i_cfg.settle_ticks) begin
                    if (w_pressed != 3'd0) begin
                        w_done    = 1'b1;
                        w_code    = r_base + w_row_add;
                        w_beep    = 1'b1;
                        n_phase   = PH_IDLE;
                        n_pattern = COL_IDLE;
                        n_deb     = '0;
                        n_settle  = '0;
                    end else if (r_col >= LAST_COL) begin
                        w_done    = 1'b1;
                        n_phase   = PH_IDLE;
                        n_pattern = COL_IDLE;
                        n_deb     = '0;
                        n_settle  = '0;
                    end else begin
                        n_base    = r_base + 5'd3;
                        n_col     = r_col + 3'd1;
                        n_pattern = {r_pattern[6:0], 1'b1};
                        n_settle  = '0;
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
                if (i_item.begin_scan) begin
                    if (i_item.override_key != 5'd0) begin
                        // injected code reported at once, no beep
                        w_done    = 1'b1;
                        w_code    = i_item.override_key;
                        n_pattern = COL_IDLE;
                        n_deb     = '0;
                        n_settle  = '0;
                    end else begin
                        n_deb    = '0;
                        w_do_deb = 1'b1;
                    end
                end
            end
        endcase

        // start key sample, shared by the request tick and the debounce phase
        w_deb_cnt = n_deb + 4'd1;
        if (w_do_deb) begin
            if (i_item.start_pin) begin
                n_phase   = PH_SCAN;
                n_col     = '0;
                n_pattern = COL_FIRST;
                n_settle  = '0;
                n_base    = '0;
            end else if (w_deb_cnt >= i_cfg.debounce_samples) begin
                w_done    = 1'b1;
                w_code    = i_cfg.start_key_code;
                w_beep    = 1'b1;
                n_phase   = PH_IDLE;
                n_pattern = COL_IDLE;
                n_deb     = '0;
                n_settle  = '0;
            end else begin
                n_phase = PH_DEBOUNCE;
                n_deb   = w_deb_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_col     <= '0;
            r_pattern <= COL_IDLE;
            r_settle  <= '0;
            r_deb     <= '0;
            r_base    <= '0;
        end else if (i_take) begin
            r_phase   <= n_phase;
            r_col     <= n_col;
            r_pattern <= n_pattern;
            r_settle  <= n_settle;
            r_deb     <= n_deb;
            r_base    <= n_base;
        end
    end

    always_comb begin
        o_res.column_drive = n_pattern;
        o_res.busy_res     = (n_phase != PH_IDLE);
        o_res.done_res     = w_done;
        o_res.key_code     = w_code;
        o_res.beep         = w_beep;
    end

endmodule

`default_nettype wire

### rtl/kps_out_stage.sv
// result register stage of the keypad scanner
`default_nettype none

module kps_out_stage
    import kps_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_load,
    output logic          o_room,
    input  wire t_kps_res i_res,
    output logic          o_valid,
    input  wire logic     i_ready,
    output t_kps_res      o_res
);

    logic     r_valid;
    logic     n_valid;
    t_kps_res r_res;

    assign o_room = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

`default_nettype wire

### rtl/matrix_keypad_scanner.sv
// top level of the matrix keypad scanner
// Each input transaction is one tick of the keypad pins and yields exactly one
// result transaction. A transaction goes input register -> scan state machine
// -> result register: an accepted tick is held in the input register, and the
// state machine's result for it is registered in the result register. A new
// transaction is taken every cycle while the result side keeps up; the rate
// of one per cycle is set by the state update of the scan state machine, which
// steps once per taken tick. A stalled result holds the state machine and, once
// both registers are full, the input. On a tick with
// begin_scan while idle, a nonzero override_key is returned at once without a
// beep. Otherwise the start pin is debounced: debounce_samples consecutive low
// samples return start_key_code with a beep, while a high sample starts the
// column scan on that tick. Columns are driven low one after another, each for
// settle_ticks ticks, and the rows are read on the last tick of each column;
// the first column with a pressed row returns 3*column + row (row 3 highest
// priority) with a beep, and no pressed key after the last column returns 0.
// Registers are written through i_cfg_we / i_cfg_idx / i_cfg_data and should
// only be changed while no scan is busy.
`default_nettype none

module matrix_keypad_scanner
    import kps_pkg::*;
#(
    parameter int NUM_COLUMNS = 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    kps_in_if.sink                     i_in,
    kps_out_if.source                  o_out,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    // configuration registers
    t_kps_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.settle_ticks     <= SETTLE_RESET;
            r_cfg.debounce_samples <= DEBOUNCE_RESET;
            r_cfg.start_key_code   <= START_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SETTLE_TICKS:     r_cfg.settle_ticks     <= i_cfg_data;
                CFG_DEBOUNCE_SAMPLES: r_cfg.debounce_samples <= i_cfg_data[3:0];
                CFG_START_KEY_CODE:   r_cfg.start_key_code   <= i_cfg_data[4:0];
                default: begin
                    // unknown index, write dropped
                end
            endcase
        end
    end

    // input transaction unpacked from the channel
    t_kps_in  w_in_item;
    t_kps_in  w_s1_item;
    logic     w_s1_valid;
    logic     w_out_room;
    logic     w_take;
    t_kps_res w_step_res;
    t_kps_res w_out_res;

    always_comb begin
        w_in_item.begin_scan   = i_in.begin_scan;
        w_in_item.start_pin    = i_in.start_pin;
        w_in_item.row_pins     = i_in.row_pins;
        w_in_item.override_key = i_in.override_key;
    end

    // the state machine steps whenever the held tick can move into the result register
    assign w_take = w_s1_valid && w_out_room;

    kps_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_item  (w_in_item),
        .i_take  (w_take),
        .o_valid (w_s1_valid),
        .o_item  (w_s1_item)
    );

    kps_step #(
        .NUM_COLUMNS (NUM_COLUMNS)
    ) u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_take),
        .i_item  (w_s1_item),
        .i_cfg   (r_cfg),
        .o_res   (w_step_res)
    );

    kps_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_take),
        .o_room  (w_out_room),
        .i_res   (w_step_res),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_res   (w_out_res)
    );

    // result transaction onto the channel
    assign o_out.column_drive = w_out_res.column_drive;
    assign o_out.busy_res     = w_out_res.busy_res;
    assign o_out.done_res     = w_out_res.done_res;
    assign o_out.key_code     = w_out_res.key_code;
    assign o_out.beep         = w_out_res.beep;

endmodule

`default_nettype wire

### rtl/kps_checker.sv
// port-level checks of the keypad scanner and their binding
`default_nettype none

module kps_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] i_column_drive,
    input wire logic       i_busy_res,
    input wire logic       i_done_res,
    input wire logic [4:0] i_key_code,
    input wire logic       i_beep
);

    // a finished scan always leaves the block idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_done_res |-> !i_busy_res)
        else $error("done result while still busy");

    // no column is driven while idle
    a_idle_cols: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_busy_res |-> i_column_drive == 8'hFF)
        else $error("column driven while idle");

    // beep and a key code only on a done transaction
    a_beep_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_beep || i_key_code != 5'd0) |-> i_done_res)
        else $error("beep or key code without done");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_column_drive)
            && $stable(i_key_code) && $stable(i_done_res))
        else $error("stalled result changed");

endmodule

bind matrix_keypad_scanner kps_checker u_kps_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_column_drive (o_out.column_drive),
    .i_busy_res     (o_out.busy_res),
    .i_done_res     (o_out.done_res),
    .i_key_code     (o_out.key_code),
    .i_beep         (o_out.beep)
);

`default_nettype wire
